@@ design/mfde_pkg.sv @@
// Package for the monochrome framebuffer draw engine.
// Holds the request codes, the controller state type and the command and status structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mfde_pkg;

	localparam logic [2:0] REQ_PIXEL   = 3'd0;
	localparam logic [2:0] REQ_SPAN    = 3'd1;
	localparam logic [2:0] REQ_RECT    = 3'd2;
	localparam logic [2:0] REQ_OUTLINE = 3'd3;
	localparam logic [2:0] REQ_READ    = 3'd4;

	localparam int unsigned WORDS_PER_COL = 16;
	localparam logic [9:0]  ROWS_PER_COL  = 10'd512;
	localparam logic [31:0] ALL_ONES      = 32'hFFFF_FFFF;

	typedef enum logic [7:0] {
		ST_CLEAR = 8'b0000_0001,
		ST_IDLE  = 8'b0000_0010,
		ST_DISP  = 8'b0000_0100,
		ST_SPAN  = 8'b0000_1000,
		ST_RD    = 8'b0001_0000,
		ST_WR    = 8'b0010_0000,
		ST_RDW   = 8'b0100_0000,
		ST_DONE  = 8'b1000_0000
	} state_t;

	typedef struct packed {
		logic load;
		logic clr_wr;
		logic span_init;
		logic next_span;
		logic mem_rd;
		logic mem_wr;
		logic word_rd;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic is_read;
		logic is_draw;
		logic col_done;
		logic span_ok;
		logic word_last;
	} status_t;

endpackage

`default_nettype wire

@@ design/mono_framebuffer_draw_engine_core.sv @@
// Once a command is accepted, a read word passes ST_DISP and ST_RDW before ST_DONE; a draw
// passes ST_DISP, ST_SPAN per column span and ST_RD, ST_WR per framebuffer word touched.
// One command at a time through the single memory port; busy drops after the result cycle.
// Reset starts a clearing pass over all COLUMNS*16 words (16384 by default) with busy held high.
// The receiver cannot stall: each result is shown for one cycle on result_strobe.
// Depends on mfde_pkg, mfde_ctrl and mfde_dp.
`timescale 1ns / 1ps
`default_nettype none

module mono_framebuffer_draw_engine_core #(
	parameter int COLUMNS = 1024
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [2:0]  req_type,
	input  wire logic [9:0]  col_start,
	input  wire logic [8:0]  row_start,
	input  wire logic [10:0] col_end,
	input  wire logic [9:0]  row_end,
	input  wire logic        pixel_value,
	input  wire logic [13:0] read_addr,
	output logic             result_strobe,
	output logic [31:0]      read_data,
	output logic             done_res
);

	mfde_pkg::cmd_t    cmd;
	mfde_pkg::status_t status;

	mfde_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.status        (status),
		.cmd           (cmd),
		.busy          (busy),
		.result_strobe (result_strobe)
	);

	mfde_dp #(
		.COLUMNS (COLUMNS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.req_type    (req_type),
		.col_start   (col_start),
		.row_start   (row_start),
		.col_end     (col_end),
		.row_end     (row_end),
		.pixel_value (pixel_value),
		.read_addr   (read_addr),
		.read_data   (read_data)
	);

	assign done_res = 1'b1;

endmodule

`default_nettype wire

@@ design/mfde_ctrl.sv @@
// Controller state machine of the draw engine.
// Sequences the clearing pass, the column spans and the read-modify-write of each word.
// Depends on mfde_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mfde_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire mfde_pkg::status_t status,
	output mfde_pkg::cmd_t         cmd,
	output logic                   busy,
	output logic                   result_strobe
);

	mfde_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mfde_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			mfde_pkg::ST_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (status.clr_last) begin
					state_d = mfde_pkg::ST_IDLE;
				end
			end
			mfde_pkg::ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = mfde_pkg::ST_DISP;
				end
			end
			mfde_pkg::ST_DISP: begin
				if (status.is_read) begin
					state_d = mfde_pkg::ST_RDW;
				end else if (status.is_draw) begin
					state_d = mfde_pkg::ST_SPAN;
				end else begin
					state_d = mfde_pkg::ST_DONE;
				end
			end
			mfde_pkg::ST_SPAN: begin
				if (status.col_done) begin
					state_d = mfde_pkg::ST_DONE;
				end else if (status.span_ok) begin
					cmd.span_init = 1'b1;
					state_d       = mfde_pkg::ST_RD;
				end else begin
					cmd.next_span = 1'b1;
				end
			end
			mfde_pkg::ST_RD: begin
				cmd.mem_rd = 1'b1;
				state_d    = mfde_pkg::ST_WR;
			end
			mfde_pkg::ST_WR: begin
				cmd.mem_wr = 1'b1;
				if (status.word_last) begin
					cmd.next_span = 1'b1;
					state_d       = mfde_pkg::ST_SPAN;
				end else begin
					state_d = mfde_pkg::ST_RD;
				end
			end
			mfde_pkg::ST_RDW: begin
				cmd.word_rd = 1'b1;
				state_d     = mfde_pkg::ST_DONE;
			end
			mfde_pkg::ST_DONE: begin
				cmd.emit = 1'b1;
				state_d  = mfde_pkg::ST_IDLE;
			end
			default: begin
				state_d = mfde_pkg::ST_IDLE;
			end
		endcase
	end

	assign busy          = (state_q != mfde_pkg::ST_IDLE);
	assign result_strobe = (state_q == mfde_pkg::ST_DONE);

endmodule

`default_nettype wire

@@ design/mfde_dp.sv @@
// Datapath of the draw engine: command registers, span and mask logic and the framebuffer.
// Executes the commands of the controller and reports status back to it.
// Depends on mfde_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mfde_dp #(
	parameter int COLUMNS = 1024
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire mfde_pkg::cmd_t cmd,
	output mfde_pkg::status_t   status,
	input  wire logic [2:0]     req_type,
	input  wire logic [9:0]     col_start,
	input  wire logic [8:0]     row_start,
	input  wire logic [10:0]    col_end,
	input  wire logic [9:0]     row_end,
	input  wire logic           pixel_value,
	input  wire logic [13:0]    read_addr,
	output logic [31:0]         read_data
);

	localparam int DEPTH = COLUMNS * mfde_pkg::WORDS_PER_COL;
	localparam int AW    = $clog2(DEPTH);

	logic [31:0]   mem [DEPTH];
	logic [31:0]   rdata_q;
	logic [AW-1:0] clr_q;
	logic [2:0]    type_q;
	logic [10:0]   x_q, x0_q, xe_q;
	logic [8:0]    ry0_q;
	logic [9:0]    ry1_q;
	logic          set_q;
	logic [13:0]   raddr_q;
	logic          pass_q;
	logic [3:0]    word_q;

	logic          interior;
	logic [8:0]    ry1m1, sy0, sy_last;
	logic [4:0]    lo, hib;
	logic [31:0]   mask, wr_word, wdata;
	logic [AW-1:0] draw_addr, raddr, waddr;
	logic          we, re, addr_ok;

	function automatic logic [8:0] ry1m1_calc(input logic [9:0] v);
		logic [9:0] t;
		t = v - 10'd1;
		return t[8:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_wr) begin
			clr_q <= clr_q + AW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			type_q  <= req_type;
			x_q     <= {1'b0, col_start};
			x0_q    <= {1'b0, col_start};
			ry0_q   <= row_start;
			set_q   <= pixel_value;
			raddr_q <= read_addr;
			pass_q  <= 1'b0;
			if (req_type == mfde_pkg::REQ_RECT || req_type == mfde_pkg::REQ_OUTLINE) begin
				xe_q <= col_end;
			end else begin
				xe_q <= {1'b0, col_start} + 11'd1;
			end
			if (req_type == mfde_pkg::REQ_PIXEL) begin
				ry1_q <= {1'b0, row_start} + 10'd1;
			end else if (row_end > mfde_pkg::ROWS_PER_COL) begin
				ry1_q <= mfde_pkg::ROWS_PER_COL;
			end else begin
				ry1_q <= row_end;
			end
		end
		if (cmd.span_init) begin
			word_q <= sy0[8:5];
		end else if (cmd.mem_wr) begin
			word_q <= word_q + 4'd1;
		end
		if (cmd.next_span) begin
			if (interior && !pass_q) begin
				pass_q <= 1'b1;
			end else begin
				pass_q <= 1'b0;
				x_q    <= x_q + 11'd1;
			end
		end
	end

	// Columns strictly inside an outline only get their top and bottom pixels.
	assign interior = (type_q == mfde_pkg::REQ_OUTLINE) && (x_q != x0_q) &&
		(x_q != xe_q - 11'd1);
	assign ry1m1    = ry1m1_calc(ry1_q);
	assign sy0      = (interior && pass_q) ? ry1m1 : ry0_q;
	assign sy_last  = (interior && !pass_q) ? ry0_q : ry1m1;

	assign lo   = (word_q == sy0[8:5]) ? sy0[4:0] : 5'd0;
	assign hib  = status.word_last ? sy_last[4:0] : 5'd31;
	assign mask = (mfde_pkg::ALL_ONES >> (5'd31 - hib)) & (mfde_pkg::ALL_ONES << lo);

	assign wr_word   = set_q ? (rdata_q | mask) : (rdata_q & ~mask);
	assign draw_addr = AW'({x_q, word_q});
	assign addr_ok   = (32'(raddr_q) < DEPTH);

	assign re    = cmd.mem_rd | cmd.word_rd;
	assign raddr = cmd.word_rd ? AW'(raddr_q) : draw_addr;
	assign we    = cmd.clr_wr | cmd.mem_wr;
	assign waddr = cmd.clr_wr ? clr_q : draw_addr;
	assign wdata = cmd.clr_wr ? 32'd0 : wr_word;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign status.clr_last  = (clr_q == AW'(DEPTH - 1));
	assign status.is_read   = (type_q == mfde_pkg::REQ_READ);
	assign status.is_draw   = (type_q == mfde_pkg::REQ_PIXEL) || (type_q == mfde_pkg::REQ_SPAN) ||
		(type_q == mfde_pkg::REQ_RECT) || (type_q == mfde_pkg::REQ_OUTLINE);
	assign status.col_done  = (x_q >= xe_q);
	assign status.span_ok   = (32'(x_q) < COLUMNS) && (ry1_q > {1'b0, ry0_q});
	assign status.word_last = (word_q == sy_last[8:5]);

	assign read_data = (cmd.emit && status.is_read && addr_ok) ? rdata_q : 32'd0;

endmodule

`default_nettype wire

@@ design/mfde_chk.sv @@
// Port-level checker for the draw engine, attached to the top level by a bind statement.
// Depends only on the ports of mono_framebuffer_draw_engine_core.
`timescale 1ns / 1ps
`default_nettype none

module mfde_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic        result_strobe,
	input wire logic [31:0] read_data,
	input wire logic        done_res
);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted word did not raise busy");

	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> busy)
		else $error("result shown while idle");

	a_strobe_single: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |=> !result_strobe && !busy)
		else $error("result strobe longer than one cycle");

	a_data_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!result_strobe |-> read_data == 32'd0)
		else $error("read data driven outside a result");

	a_done_flag: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> done_res)
		else $error("result without done flag");

endmodule

bind mono_framebuffer_draw_engine_core mfde_chk u_mfde_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.result_strobe (result_strobe),
	.read_data     (read_data),
	.done_res      (done_res)
);

`default_nettype wire
